FILE: rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin thread slot scheduler package
// Shared slot status codes, operation codes and the "no slot" code.
// ----------------------------------------------------------------------------
package rrts_pkg;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_DEAD    = 2'd3
    } slot_status_t;

    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_PICK   = 2'd1;
    localparam logic [1:0] MODE_SET    = 2'd2;
    localparam logic [1:0] MODE_EXIT   = 2'd3;

    localparam logic [3:0] SLOT_NONE = 4'hF;

endpackage

FILE: rtl/rrts_ifs.sv
// ----------------------------------------------------------------------------
// Round-robin thread slot scheduler channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface rrts_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic signed [3:0] target_slot;

    modport source (output valid, output mode, output target_slot, input ready);
    modport sink   (input valid, input mode, input target_slot, output ready);
endinterface

interface rrts_rsp_if;
    logic              valid;
    logic              ready;
    logic signed [3:0] result_slot;
    logic [3:0]        live_threads;

    modport source (output valid, output result_slot, output live_threads, input ready);
    modport sink   (input valid, input result_slot, input live_threads, output ready);
endinterface

FILE: rtl/rrts_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rrts_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/round_robin_thread_slot_scheduler_core.sv
// ----------------------------------------------------------------------------
// Round-robin thread slot scheduler core
// Slot status table in a RAM with a sequencer for create, pick, set-current
// and exit operations.
// ----------------------------------------------------------------------------
// Each request word on req carries an operation (mode) and a target slot.
// Each request produces exactly one response word on rsp, in order, with
// the affected slot index (or -1) and the live thread count after the
// operation. Create and pick scan the status RAM one entry per cycle,
// with the RAM read pipelined against the compare; a pick with no live
// thread skips the scan. A set-current to a valid slot reads and checks
// it, then reads a different current slot and returns it to ready if it
// was running, before it marks the target as running. Exit reads the
// current slot and marks it dead if it is running, or answers without a
// RAM access when there is no current slot.
// Only one request is in flight at a time; req.ready is high while the
// sequencer is idle, even when a response word still waits on rsp.
// If the receiver stalls, the finished response waits in the output
// register and the next request holds before its result is loaded.
// Reset clears all valid bits of the table, so every slot reads as free,
// clears the current slot and sets the live count to zero, all at once.
// ----------------------------------------------------------------------------
module round_robin_thread_slot_scheduler_core
    import rrts_pkg::*;
#(
    parameter int THREAD_SLOTS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    rrts_req_if.sink  req,
    rrts_rsp_if.source rsp
);

    localparam int SLOT_W = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int CNT_W  = $clog2(THREAD_SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(THREAD_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TGT_RD,
        S_TGT_CK,
        S_CUR_RD,
        S_CUR_CK,
        S_TGT_WR,
        S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic                clr_reg, clr_next;
    logic [SLOT_W-1:0]   tgt_reg, tgt_next;
    logic                run_vld_reg, run_vld_next;
    logic [SLOT_W-1:0]   run_reg, run_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [THREAD_SLOTS-1:0] vld_reg, vld_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [SLOT_W-1:0]   scan_addr_reg, scan_addr_next;
    logic [CNT_W-1:0]    scan_left_reg, scan_left_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [SLOT_W-1:0]   chk_addr_reg, chk_addr_next;
    logic [3:0]          res_reg, res_next;
    logic                out_vld_reg, out_vld_next;
    logic [3:0]          out_slot_reg, out_slot_next;
    logic [3:0]          out_live_reg, out_live_next;

    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    logic [1:0]          wr_data;
    logic [SLOT_W-1:0]   rd_addr;
    logic [1:0]          rd_data;
    slot_status_t        cur_status;
    slot_status_t        scan_match;
    logic                tgt_in_range;

    rrts_ram #(
        .WIDTH (2),
        .DEPTH (1 << SLOT_W)
    ) u_status_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cur_status   = rd_vld_reg ? slot_status_t'(rd_data) : ST_FREE;
    assign scan_match   = (op_reg == MODE_CREATE) ? ST_FREE : ST_READY;
    assign tgt_in_range = (32'(req.target_slot[2:0]) < THREAD_SLOTS);

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_vld_reg;
    assign rsp.result_slot  = out_slot_reg;
    assign rsp.live_threads = out_live_reg;

    always_comb
    begin
        case (state_reg)
            S_SCAN:   rd_addr = scan_addr_reg;
            S_TGT_RD: rd_addr = tgt_reg;
            default:  rd_addr = run_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        clr_next       = clr_reg;
        tgt_next       = tgt_reg;
        run_vld_next   = run_vld_reg;
        run_next       = run_reg;
        cnt_next       = cnt_reg;
        vld_next       = vld_reg;
        rd_vld_next    = vld_reg[rd_addr];
        scan_addr_next = scan_addr_reg;
        scan_left_next = scan_left_reg;
        chk_vld_next   = chk_vld_reg;
        chk_addr_next  = chk_addr_reg;
        res_next       = res_reg;
        out_vld_next   = out_vld_reg && !rsp.ready;
        out_slot_next  = out_slot_reg;
        out_live_next  = out_live_reg;
        wr_en          = 1'b0;
        wr_addr        = run_reg;
        wr_data        = ST_FREE;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next        = req.mode;
                    clr_next       = req.target_slot[3];
                    tgt_next       = SLOT_W'(req.target_slot[2:0]);
                    res_next       = SLOT_NONE;
                    chk_vld_next   = 1'b0;
                    scan_left_next = CNT_W'(THREAD_SLOTS);
                    scan_addr_next = '0;
                    case (req.mode)
                        MODE_CREATE:
                        begin
                            state_next = S_SCAN;
                        end
                        MODE_PICK:
                        begin
                            if (cnt_reg == '0)
                            begin
                                state_next = S_OUT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                                if (run_vld_reg)
                                begin
                                    scan_addr_next = (run_reg == LAST_SLOT) ? '0 : run_reg + 1'b1;
                                end
                            end
                        end
                        MODE_SET:
                        begin
                            if (req.target_slot[3])
                            begin
                                state_next = run_vld_reg ? S_CUR_RD : S_OUT;
                            end
                            else if (tgt_in_range)
                            begin
                                state_next = S_TGT_RD;
                            end
                            else
                            begin
                                state_next = S_OUT;
                            end
                        end
                        default:
                        begin
                            state_next = run_vld_reg ? S_CUR_RD : S_OUT;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (chk_vld_reg && cur_status == scan_match)
                begin
                    res_next   = 4'(chk_addr_reg);
                    state_next = S_OUT;
                    if (op_reg == MODE_CREATE)
                    begin
                        wr_en                  = 1'b1;
                        wr_addr                = chk_addr_reg;
                        wr_data                = ST_READY;
                        vld_next[chk_addr_reg] = 1'b1;
                        cnt_next               = cnt_reg + 1'b1;
                    end
                end
                else if (scan_left_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    scan_addr_next = (scan_addr_reg == LAST_SLOT) ? '0 : scan_addr_reg + 1'b1;
                    scan_left_next = scan_left_reg - 1'b1;
                    chk_vld_next   = 1'b1;
                    chk_addr_next  = scan_addr_reg;
                end
            end

            S_TGT_RD:
            begin
                state_next = S_TGT_CK;
            end

            S_TGT_CK:
            begin
                if (cur_status == ST_READY || cur_status == ST_RUNNING)
                begin
                    if (run_vld_reg && run_reg != tgt_reg)
                    begin
                        state_next = S_CUR_RD;
                    end
                    else
                    begin
                        state_next = S_TGT_WR;
                    end
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_CUR_RD:
            begin
                state_next = S_CUR_CK;
            end

            S_CUR_CK:
            begin
                if (op_reg == MODE_EXIT)
                begin
                    state_next = S_OUT;
                    if (cur_status == ST_RUNNING)
                    begin
                        wr_en    = 1'b1;
                        wr_data  = ST_DEAD;
                        res_next = 4'(run_reg);
                        if (cnt_reg != '0)
                        begin
                            cnt_next = cnt_reg - 1'b1;
                        end
                    end
                end
                else
                begin
                    if (cur_status == ST_RUNNING)
                    begin
                        wr_en   = 1'b1;
                        wr_data = ST_READY;
                    end
                    if (clr_reg)
                    begin
                        run_vld_next = 1'b0;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        state_next = S_TGT_WR;
                    end
                end
            end

            S_TGT_WR:
            begin
                wr_en             = 1'b1;
                wr_addr           = tgt_reg;
                wr_data           = ST_RUNNING;
                vld_next[tgt_reg] = 1'b1;
                run_vld_next      = 1'b1;
                run_next          = tgt_reg;
                res_next          = 4'(tgt_reg);
                state_next        = S_OUT;
            end

            S_OUT:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next  = 1'b1;
                    out_slot_next = res_reg;
                    out_live_next = 4'(cnt_reg);
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            run_vld_reg   <= 1'b0;
            run_reg       <= '0;
            cnt_reg       <= '0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            chk_vld_reg   <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_vld_reg   <= run_vld_next;
            run_reg       <= run_next;
            cnt_reg       <= cnt_next;
            vld_reg       <= vld_next;
            rd_vld_reg    <= rd_vld_next;
            chk_vld_reg   <= chk_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        clr_reg       <= clr_next;
        tgt_reg       <= tgt_next;
        scan_addr_reg <= scan_addr_next;
        scan_left_reg <= scan_left_next;
        chk_addr_reg  <= chk_addr_next;
        res_reg       <= res_next;
        out_slot_reg  <= out_slot_next;
        out_live_reg  <= out_live_next;
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin thread slot scheduler core testbench
// Drives create, pick, set-current and exit requests: a directed pass over the
// empty table, slot creation, round-robin picks and exits, then a random run,
// then fills the table and retires every live thread. A local model of the
// slot table predicts each response word, and the checker compares them in
// order. Both channels idle in random bursts except from the last 100 random requests on.
// ----------------------------------------------------------------------------
module tb;
    import rrts_pkg::*;

    localparam int SLOTS = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [1:0]        op;
        logic signed [3:0] slot;
        logic [3:0]        live;
    } sched_result_t;

    logic clk;
    logic rst_n;

    rrts_req_if req_ch ();
    rrts_rsp_if rsp_ch ();

    round_robin_thread_slot_scheduler_core #(
        .THREAD_SLOTS(SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    slot_status_t  slot_table [SLOTS];
    bit            cur_valid;
    int unsigned   cur_slot;
    int unsigned   live_cnt;
    sched_result_t pending_results [$];

    int  error_count;
    int  ops_seen [4];
    int  hits_seen [4];
    int  idle_cycles;
    bit  quiet_phase;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic release_running();
        if (cur_valid && cur_slot < SLOTS && slot_table[cur_slot] == ST_RUNNING)
        begin
            slot_table[cur_slot] = ST_READY;
        end
    endtask

    task automatic schedule_op(input logic [1:0] op, input logic signed [3:0] tgt,
                               output logic signed [3:0] slot, output logic [3:0] live);
        int unsigned start;
        int unsigned k;
        int          t;
        bit          hit;
        slot = SLOT_NONE;
        hit = 1'b0;
        t = int'(tgt);
        case (op)
            MODE_CREATE:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!hit && slot_table[i] == ST_FREE)
                    begin
                        slot_table[i] = ST_READY;
                        live_cnt++;
                        slot = 4'(i);
                        hit = 1'b1;
                    end
                end
            end
            MODE_PICK:
            begin
                if (live_cnt != 0)
                begin
                    start = cur_valid ? (cur_slot + 1) % SLOTS : 0;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        k = (start + i) % SLOTS;
                        if (!hit && slot_table[k] == ST_READY)
                        begin
                            slot = 4'(k);
                            hit = 1'b1;
                        end
                    end
                end
            end
            MODE_SET:
            begin
                if (t < 0)
                begin
                    release_running();
                    cur_valid = 1'b0;
                    cur_slot = 0;
                end
                else if (t < SLOTS &&
                         (slot_table[t] == ST_READY || slot_table[t] == ST_RUNNING))
                begin
                    if (!(cur_valid && cur_slot == t))
                    begin
                        release_running();
                    end
                    cur_valid = 1'b1;
                    cur_slot = t;
                    slot_table[t] = ST_RUNNING;
                    slot = tgt;
                end
            end
            default:
            begin
                if (cur_valid && cur_slot < SLOTS && slot_table[cur_slot] == ST_RUNNING)
                begin
                    slot_table[cur_slot] = ST_DEAD;
                    if (live_cnt > 0)
                    begin
                        live_cnt--;
                    end
                    slot = 4'(cur_slot);
                end
            end
        endcase
        live = 4'(live_cnt);
    endtask

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        error_count++;
        $display("%0t: mismatch in %s: expected %0d, got %0d", $time, what, exp_val, got_val);
    endtask

    // Requests are predicted at acceptance; responses are checked in order.
    always @(posedge clk)
    begin
        sched_result_t     exp_word;
        logic signed [3:0] slot;
        logic [3:0]        live;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            schedule_op(req_ch.mode, req_ch.target_slot, slot, live);
            exp_word.op = req_ch.mode;
            exp_word.slot = slot;
            exp_word.live = live;
            pending_results.push_back(exp_word);
            ops_seen[req_ch.mode]++;
            if (slot != SLOT_NONE)
            begin
                hits_seen[req_ch.mode]++;
            end
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected response word, slot", -1, int'(rsp_ch.result_slot));
            end
            else
            begin
                exp_word = pending_results.pop_front();
                if (rsp_ch.result_slot !== exp_word.slot)
                begin
                    report_mismatch($sformatf("result_slot (mode %0d)", exp_word.op),
                                    int'(exp_word.slot), int'(rsp_ch.result_slot));
                end
                if (rsp_ch.live_threads !== exp_word.live)
                begin
                    report_mismatch($sformatf("live_threads (mode %0d)", exp_word.op),
                                    int'(exp_word.live), int'(rsp_ch.live_threads));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** round_robin_thread_slot_scheduler_core: FAILED **");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n || quiet_phase)
            begin
                rsp_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 15);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic idle_sender(input int cycles);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        req_ch.mode <= 2'($urandom_range(0, 3));
        req_ch.target_slot <= 4'($urandom_range(0, 15));
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic send_word(input logic [1:0] op, input logic signed [3:0] tgt);
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.mode <= op;
        req_ch.target_slot <= tgt;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            idle_sender($urandom_range(1, 16));
        end
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic test_empty_table();
        send_word(MODE_PICK, 4'sd0);
        send_word(MODE_EXIT, 4'sd7);
        send_word(MODE_SET, 4'sd5);
        send_word(MODE_SET, 4'sd7);
        send_word(MODE_SET, -4'sd1);
    endtask

    task automatic test_create_order();
        send_word(MODE_CREATE, -4'sd8);
        send_word(MODE_CREATE, -4'sd1);
        send_word(MODE_CREATE, 4'sd7);
    endtask

    task automatic test_pick_set_exit();
        send_word(MODE_PICK, -4'sd1);
        send_word(MODE_SET, 4'sd2);
        send_word(MODE_PICK, 4'sd5);
        send_word(MODE_SET, 4'sd2);
        send_word(MODE_SET, 4'sd1);
        send_word(MODE_PICK, 4'sd0);
        send_word(MODE_EXIT, 4'sd0);
        send_word(MODE_EXIT, -4'sd8);
        send_word(MODE_PICK, 4'sd3);
        send_word(MODE_SET, 4'sd1);
        send_word(MODE_SET, 4'sd0);
        send_word(MODE_SET, -4'sd8);
        send_word(MODE_PICK, 4'sd7);
    endtask

    task automatic test_random_traffic(input int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
            begin
                wait_results_drained();
            end
            if (n == count - 100)
            begin
                quiet_phase = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                send_word(MODE_CREATE, 4'($urandom_range(0, 15)));
            end
            else if (r < 45 || (r >= 95 && live_cnt <= 2))
            begin
                send_word(MODE_PICK, 4'($urandom_range(0, 15)));
            end
            else if (r < 95)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    send_word(MODE_SET, 4'($urandom_range(8, 15)));
                end
                else
                begin
                    send_word(MODE_SET, 4'($urandom_range(0, SLOTS - 1)));
                end
            end
            else
            begin
                send_word(MODE_EXIT, 4'($urandom_range(0, 15)));
            end
        end
    endtask

    task automatic test_fill_and_retire();
        wait_results_drained();
        for (int s = 0; s <= SLOTS; s++)
        begin
            send_word(MODE_CREATE, 4'($urandom_range(0, 15)));
        end
        for (int s = 0; s < SLOTS; s++)
        begin
            wait_results_drained();
            if (slot_table[s] == ST_READY || slot_table[s] == ST_RUNNING)
            begin
                send_word(MODE_SET, 4'(s));
                send_word(MODE_EXIT, 4'($urandom_range(0, 15)));
            end
        end
        send_word(MODE_PICK, 4'sd0);
        send_word(MODE_EXIT, 4'sd0);
        send_word(MODE_CREATE, 4'sd0);
        send_word(MODE_SET, 4'sd0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_CREATE;
        req_ch.target_slot = 4'sd0;
        quiet_phase = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        cur_valid = 1'b0;
        cur_slot = 0;
        live_cnt = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_table[i] = ST_FREE;
        end
        for (int i = 0; i < 4; i++)
        begin
            ops_seen[i] = 0;
            hits_seen[i] = 0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_create_order();
        test_pick_set_exit();
        test_random_traffic(560);
        test_fill_and_retire();

        wait_results_drained();
        repeat (30) @(posedge clk);
        $display("Ran %0d creates (%0d granted), %0d picks (%0d found), %0d set-current (%0d taken),",
                 ops_seen[MODE_CREATE], hits_seen[MODE_CREATE], ops_seen[MODE_PICK],
                 hits_seen[MODE_PICK], ops_seen[MODE_SET], hits_seen[MODE_SET]);
        $display("and %0d exits (%0d retired a thread), with %0d mismatches.",
                 ops_seen[MODE_EXIT], hits_seen[MODE_EXIT], error_count);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("** round_robin_thread_slot_scheduler_core: PASSED **");
        end
        else
        begin
            $display("** round_robin_thread_slot_scheduler_core: FAILED **");
        end
        $finish;
    end
endmodule
